// ===== src/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types, constants and helpers of the line substring counter.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int PATTERN_BYTES   = 16;
    localparam int MAX_PATTERN_DEF = 16;
    localparam int OUTQ_DEPTH      = 4;
    localparam int LEN_W           = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int CNT_W           = 32;

    localparam logic [7:0]       NEWLINE    = 8'd10;
    localparam logic             KIND_LINE  = 1'b0;
    localparam logic             KIND_TOTAL = 1'b1;
    localparam logic [CNT_W-1:0] SAT32      = {CNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_PATTERN_LOW    = 2'd1,
        REG_PATTERN_HIGH   = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic             report_kind;
        logic [CNT_W-1:0] line_number;
        logic [CNT_W-1:0] line_matches;
        logic [CNT_W-1:0] total_matches;
        logic             last_result;
    } t_result;

    // Control from the item stage to the match unit.
    typedef struct packed {
        logic step;     // a text byte enters the window
        logic restart;  // line closed or text ended: restart matching
    } t_match_ctl;

    typedef logic [PATTERN_BYTES-1:0][7:0] t_pattern;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == SAT32) ? v : v + 1'b1;
    endfunction

endpackage

// ===== src/lsc_match.sv =====
// ----------------------------------------------------------------------------
// lsc_match
// Byte window and eligible-run counter with a parallel pattern compare.
// ----------------------------------------------------------------------------
module lsc_match #(
    parameter int MAX_PATTERN = lsc_pkg::MAX_PATTERN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lsc_pkg::t_match_ctl               i_ctl,
    input  logic [7:0]                        i_byte,
    input  lsc_pkg::t_pattern                 i_pattern,
    input  logic [lsc_pkg::LEN_W-1:0]         i_len,
    output logic                              o_hit
);
    import lsc_pkg::*;

    // Only the newest min(MAX_PATTERN, 16) bytes can ever be compared.
    localparam int WIN   = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;
    localparam int RUN_W = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W = (RUN_W > LEN_W) ? RUN_W : LEN_W;
    localparam int IDX_W = $clog2(PATTERN_BYTES);

    logic [7:0]       r_win [WIN];
    logic [7:0]       n_win [WIN];
    logic [RUN_W-1:0] r_run;
    logic [RUN_W-1:0] n_run;
    logic [RUN_W-1:0] w_run_inc;
    logic [WIN-1:0]   w_pos_ok;
    logic [IDX_W-1:0] w_idx [WIN];

    always_comb begin
        n_win[0] = i_byte;
        for (int k = 1; k < WIN; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    assign w_run_inc = (r_run == RUN_W'(MAX_PATTERN)) ? r_run : r_run + 1'b1;

    // Position j of the new window holds pattern byte len-1-j on a hit.
    always_comb begin
        for (int j = 0; j < WIN; j++) begin
            w_idx[j]    = IDX_W'(i_len - LEN_W'(j) - LEN_W'(1));
            w_pos_ok[j] = (LEN_W'(j) >= i_len) || (n_win[j] == i_pattern[w_idx[j]]);
        end
    end

    assign o_hit = (i_len != '0)
                && (CMP_W'(w_run_inc) >= CMP_W'(i_len))
                && (&w_pos_ok);

    always_comb begin
        n_run = r_run;
        if (i_ctl.restart) begin
            n_run = '0;
        end else if (i_ctl.step) begin
            n_run = o_hit ? '0 : w_run_inc;
        end
    end

    // Window bytes older than the run are never compared: no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else begin
            r_run <= n_run;
        end
    end

endmodule

// ===== src/lsc_outq.sv =====
// ----------------------------------------------------------------------------
// lsc_outq
// Small result queue, up to two words written and one read per cycle.
// ----------------------------------------------------------------------------
module lsc_outq #(
    parameter int DEPTH = lsc_pkg::OUTQ_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push0,
    input  lsc_pkg::t_result  i_data0,
    input  logic              i_push1,
    input  lsc_pkg::t_result  i_data1,
    output logic              o_room2,
    output logic              o_valid,
    input  logic              i_ready,
    output lsc_pkg::t_result  o_data
);
    import lsc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_result           r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_QW-1:0] r_cnt;
    logic [PTR_W-1:0]  w_wp1;
    logic              w_pop;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w_wp1   = ptr_next(r_wp);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_pop   = o_valid && i_ready;
    assign o_room2 = (r_cnt <= CNT_QW'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wp] <= i_data0;
        end
        if (i_push0 && i_push1) begin
            r_mem[w_wp1] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push0 && i_push1) begin
                r_wp <= ptr_next(w_wp1);
            end else if (i_push0) begin
                r_wp <= w_wp1;
            end
            if (w_pop) begin
                r_rp <= ptr_next(r_rp);
            end
            r_cnt <= r_cnt + CNT_QW'(i_push0) + CNT_QW'(i_push0 && i_push1)
                   - CNT_QW'(w_pop);
        end
    end

endmodule

// ===== src/line_substring_counter.sv =====
// ----------------------------------------------------------------------------
// line_substring_counter
// Counts non-overlapping pattern matches per text line and over a whole text.
// ----------------------------------------------------------------------------
// Text arrives one byte per word on the input channel. A word is held in an
// input register; when it advances, the match unit compares the newest
// bytes of the line against the configured pattern in parallel, the counters
// update, and any reports go into a four-word result queue. One input word is
// taken every cycle as long as the queue has room for two more reports, so
// the sustained rate is one byte per clock; a report enters the queue when
// its word advances out of the input register, and a stalled output only
// throttles the input once the queue holds more than two words. A newline
// closes the line and yields one line report when the line held a match (or
// always, with an empty pattern); an end-of-text word yields the final line
// report when due and then the total report, and clears all counters so a
// new text may follow. Write the pattern registers only while the block is
// idle. Counters saturate at all ones.
// ----------------------------------------------------------------------------
module line_substring_counter #(
    parameter int MAX_PATTERN = lsc_pkg::MAX_PATTERN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // text input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  lsc_pkg::t_in_item                   i_data,
    // reports
    output logic                                o_valid,
    input  logic                                i_ready,
    output lsc_pkg::t_result                    o_data,
    // register writes
    input  logic                                i_cfg_wr_en,
    input  logic [lsc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lsc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import lsc_pkg::*;

    // Pattern length in use is capped by the window and the pattern storage.
    localparam int LIM = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;

    // Configuration registers
    logic [LEN_W-1:0]      r_plen;
    logic [CFG_DATA_W-1:0] r_plo;
    logic [CFG_DATA_W-1:0] r_phi;
    logic [LEN_W-1:0]      w_len;
    t_pattern              w_pattern;

    // Input register
    logic                  r_in_valid;
    t_in_item              r_in;
    logic                  w_adv;
    logic                  w_room2;
    logic                  w_eot;
    logic                  w_nl;

    // Counters
    logic [CNT_W-1:0]      r_clm;
    logic [CNT_W-1:0]      r_lines;
    logic [CNT_W-1:0]      r_total;
    logic [CNT_W-1:0]      n_clm;
    logic [CNT_W-1:0]      n_lines;
    logic [CNT_W-1:0]      n_total;
    logic [CNT_W-1:0]      w_line_no;
    logic                  w_rpt_due;

    // Match unit and result queue hookup
    t_match_ctl            w_mctl;
    logic                  w_hit;
    logic                  w_push0;
    logic                  w_push1;
    t_result               w_res0;
    t_result               w_res1;
    t_result               w_line_rpt;
    t_result               w_total_rpt;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= '0;
            r_plo  <= '0;
            r_phi  <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_PATTERN_LENGTH: r_plen <= i_cfg_wdata[LEN_W-1:0];
                REG_PATTERN_LOW:    r_plo  <= i_cfg_wdata;
                REG_PATTERN_HIGH:   r_phi  <= i_cfg_wdata;
                default: ;  // unused index: drop the write
            endcase
        end
    end

    assign w_len     = (r_plen > LEN_W'(LIM)) ? LEN_W'(LIM) : r_plen;
    assign w_pattern = {r_phi, r_plo};

    // ---------------- input register ----------------
    // Advance the held word when the queue can absorb its worst case of two
    // reports; take a new word whenever the register empties or advances.
    assign w_adv   = r_in_valid && w_room2;
    assign o_ready = !r_in_valid || w_adv;
    assign w_eot   = r_in.end_of_text;
    assign w_nl    = !r_in.end_of_text && (r_in.text_byte == NEWLINE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
    end

    // ---------------- match unit ----------------
    assign w_mctl.step    = w_adv && !w_eot && !w_nl;
    assign w_mctl.restart = w_adv && (w_eot || w_nl);

    lsc_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_mctl),
        .i_byte    (r_in.text_byte),
        .i_pattern (w_pattern),
        .i_len     (w_len),
        .o_hit     (w_hit)
    );

    // ---------------- counters and reports ----------------
    assign w_line_no = sat_inc(r_lines);
    // A closing line reports when it matched, or always with an empty pattern.
    assign w_rpt_due = (w_len == '0) || (r_clm != '0);

    always_comb begin
        w_line_rpt.report_kind   = KIND_LINE;
        w_line_rpt.line_number   = w_line_no;
        w_line_rpt.line_matches  = r_clm;
        w_line_rpt.total_matches = r_total;
        w_line_rpt.last_result   = !w_eot;  // at end of text the total follows

        w_total_rpt.report_kind   = KIND_TOTAL;
        w_total_rpt.line_number   = '0;
        w_total_rpt.line_matches  = '0;
        w_total_rpt.total_matches = r_total;
        w_total_rpt.last_result   = 1'b1;
    end

    always_comb begin
        n_clm   = r_clm;
        n_lines = r_lines;
        n_total = r_total;
        w_push0 = 1'b0;
        w_push1 = 1'b0;
        w_res0  = w_line_rpt;
        w_res1  = w_total_rpt;
        if (w_adv) begin
            if (w_eot) begin
                // Close the last line, report the total, start over.
                n_clm   = '0;
                n_lines = '0;
                n_total = '0;
                w_push0 = 1'b1;
                w_push1 = w_rpt_due;
                if (!w_rpt_due) begin
                    w_res0 = w_total_rpt;
                end
            end else if (w_nl) begin
                n_lines = w_line_no;
                n_clm   = '0;
                w_push0 = w_rpt_due;
            end else if (w_hit) begin
                n_clm   = sat_inc(r_clm);
                n_total = sat_inc(r_total);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clm   <= '0;
            r_lines <= '0;
            r_total <= '0;
        end else begin
            r_clm   <= n_clm;
            r_lines <= n_lines;
            r_total <= n_total;
        end
    end

    // ---------------- result queue ----------------
    lsc_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (w_push0),
        .i_data0 (w_res0),
        .i_push1 (w_push1),
        .i_data1 (w_res1),
        .o_room2 (w_room2),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

`ifndef SYNTHESIS
    // End of text clears every counter.
    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_eot) |=> (r_clm == '0 && r_lines == '0 && r_total == '0))
        else $error("counters not cleared after end of text");

    // A match on a byte raises the running total or keeps it saturated.
    a_hit_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mctl.step && w_hit) |=> (r_total == sat_inc($past(r_total))))
        else $error("match not counted in total");

    // Line count only moves when a line closes.
    a_lines_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lines != $past(r_lines)) |-> $past(w_adv && (w_nl || w_eot)))
        else $error("line count changed without a line closing");

    // Never push two reports for a plain byte or a newline.
    a_two_only_eot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push1 |-> (w_push0 && w_eot))
        else $error("second report outside end of text");
`endif

endmodule

// ===== dv/tb_line_substring_counter.sv =====
// ----------------------------------------------------------------------------
// tb_line_substring_counter
// Self-checking bench for the line substring counter.
// ----------------------------------------------------------------------------
// Text words go in on the input channel and line and total reports are
// checked one by one against a predictor kept inside the bench. A short
// directed part covers the empty pattern, the non-overlapping rule, the
// oversized length with a full sixteen-byte pattern, and a pattern change in
// the middle of a line. Random texts built around the configured pattern
// follow, under several sender idle and receiver stall mixes, plus one long
// receiver hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb_line_substring_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import lsc_pkg::*;

    localparam int WINDOW        = MAX_PATTERN_DEF;
    localparam int SETTLE_CYCLES = 8;       // idle margin before a register write
    localparam int LIMIT_CYCLES  = 400000;  // watchdog
    localparam int HOLD_CYCLES   = 200;     // long receiver hold-off

    // DUT ports; every input starts at a known value
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    t_in_item              i_data      = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    t_result               o_data;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // shadow registers and predictor state
    logic [LEN_W-1:0] cfg_len;
    logic [63:0]      cfg_lo;
    logic [63:0]      cfg_hi;
    logic [7:0]       line_window [WINDOW];   // newest byte at index 0
    int unsigned      run_since_restart;
    logic [CNT_W-1:0] line_hits;
    logic [CNT_W-1:0] lines_closed;
    logic [CNT_W-1:0] text_total;

    t_result pending_reports[$];

    // bookkeeping
    int err_count      = 0;
    int words_sent     = 0;
    int reports_seen   = 0;
    int settings_used  = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int rx_stall_pct   = 0;
    int rx_hold_req    = 0;   // bumped by a test to ask for a hold-off
    int rx_hold_seen   = 0;
    int rx_hold_left   = 0;

    logic [7:0] alpha [3];    // small alphabet for random texts

    line_substring_counter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, pending_reports.size());
            $display("tb_line_substring_counter NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic logic [CNT_W-1:0] sat_up(input logic [CNT_W-1:0] v);
        return (v == SAT32) ? v : v + 1'b1;
    endfunction

    // Clip the length register to the window and the pattern store.
    function automatic int unsigned active_len();
        int unsigned n;
        n = 32'(cfg_len);
        if (n > WINDOW) n = WINDOW;
        if (n > PATTERN_BYTES) n = PATTERN_BYTES;
        return n;
    endfunction

    function automatic logic [7:0] pat_byte(input int unsigned i);
        if (i < 8) return cfg_lo[8*i +: 8];
        return cfg_hi[8*(i-8) +: 8];
    endfunction

    task automatic queue_report(input logic kind, input logic [CNT_W-1:0] line_no,
                                input logic [CNT_W-1:0] hits,
                                input logic [CNT_W-1:0] total, input logic last);
        t_result r;
        r.report_kind   = kind;
        r.line_number   = line_no;
        r.line_matches  = hits;
        r.total_matches = total;
        r.last_result   = last;
        pending_reports.push_back(r);
    endtask

    // Close the open line; a report is due on a hit or with an empty pattern.
    task automatic close_line(input logic last);
        lines_closed = sat_up(lines_closed);
        if (active_len() == 0 || line_hits != 0)
            queue_report(KIND_LINE, lines_closed, line_hits, text_total, last);
        line_hits         = '0;
        run_since_restart = 0;
    endtask

    task automatic clear_text();
        for (int i = 0; i < WINDOW; i++) line_window[i] = 8'h00;
        run_since_restart = 0;
        line_hits         = '0;
        lines_closed      = '0;
        text_total        = '0;
    endtask

    task automatic predict_word(input t_in_item w);
        int unsigned len;
        bit          hit;
        len = active_len();
        if (w.end_of_text) begin
            // the byte under an end marker is ignored
            close_line(1'b0);
            queue_report(KIND_TOTAL, '0, '0, text_total, 1'b1);
            clear_text();
        end else if (w.text_byte == NEWLINE) begin
            close_line(1'b1);
        end else begin
            for (int i = WINDOW - 1; i > 0; i--) line_window[i] = line_window[i-1];
            line_window[0] = w.text_byte;
            if (run_since_restart < WINDOW) run_since_restart++;
            if (len != 0 && run_since_restart >= len) begin
                hit = 1'b1;
                for (int i = 0; i < len; i++)
                    if (pat_byte(i) != line_window[len-1-i]) hit = 1'b0;
                if (hit) begin
                    // greedy match: restart counting eligibility
                    line_hits         = sat_up(line_hits);
                    text_total        = sat_up(text_total);
                    run_since_restart = 0;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a hold-off counted here on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold_req != rx_hold_seen) begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each accepted report with the oldest expectation
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                report_mismatch("report with none expected", o_data.line_number, '0);
            end else begin
                want = pending_reports.pop_front();
                if (o_data.report_kind !== want.report_kind)
                    report_mismatch("report_kind", CNT_W'(o_data.report_kind),
                                    CNT_W'(want.report_kind));
                if (o_data.line_number !== want.line_number)
                    report_mismatch("line_number", o_data.line_number, want.line_number);
                if (o_data.line_matches !== want.line_matches)
                    report_mismatch("line_matches", o_data.line_matches, want.line_matches);
                if (o_data.total_matches !== want.total_matches)
                    report_mismatch("total_matches", o_data.total_matches,
                                    want.total_matches);
                if (o_data.last_result !== want.last_result)
                    report_mismatch("last_result", CNT_W'(o_data.last_result),
                                    CNT_W'(want.last_result));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers; each is entered and left just after a rising edge
    // ------------------------------------------------------------------------

    // Offer one word and hold it until accepted. Valid stays high on return so
    // a following word goes out back to back; idle gaps lower it first.
    task automatic send_word(input logic [7:0] b, input logic eot);
        t_in_item w;
        w.text_byte   = b;
        w.end_of_text = eot;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_word(w);
        words_sent++;
    endtask

    // Drop valid, wait for every expected report, then let the pipe settle.
    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers; only call once the block is idle.
    task automatic set_pattern(input logic [LEN_W-1:0] len, input logic [63:0] lo,
                               input logic [63:0] hi);
        logic [63:0] junk;
        junk = {$urandom, $urandom};   // upper bits of the length write are don't-care
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_PATTERN_LENGTH;
        i_cfg_wdata <= {junk[63:LEN_W], len};
        @(posedge i_clk);
        cfg_len = len;
        i_cfg_index <= REG_PATTERN_LOW;
        i_cfg_wdata <= lo;
        @(posedge i_clk);
        cfg_lo = lo;
        i_cfg_index <= REG_PATTERN_HIGH;
        i_cfg_wdata <= hi;
        @(posedge i_clk);
        cfg_hi = hi;
        i_cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Pick a random pattern over a small alphabet so partial matches overlap.
    task automatic pick_pattern();
        logic [LEN_W-1:0] len;
        logic [63:0]      lo;
        logic [63:0]      hi;
        int               r;
        for (int i = 0; i < 3; i++) alpha[i] = 8'($urandom_range(255));
        if ($urandom_range(9) == 0) alpha[2] = NEWLINE;
        r = $urandom_range(99);
        if (r < 8)       len = '0;
        else if (r < 16) len = 5'd16;
        else if (r < 22) len = LEN_W'($urandom_range(31, 17));   // oversized, clips to 16
        else             len = LEN_W'($urandom_range(4, 1));
        for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = alpha[$urandom_range(2)];
            hi[8*i +: 8] = alpha[$urandom_range(2)];
        end
        if ($urandom_range(4) == 0) begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
        end
        set_pattern(len, lo, hi);
    endtask

    // One text: a few lines mixing pattern copies with alphabet and random
    // bytes, sometimes an unterminated last line, then the end marker.
    task automatic send_random_text();
        int         nlines;
        int         nparts;
        int         r;
        bit         noise;
        logic [7:0] b;
        noise  = ($urandom_range(19) == 0);
        nlines = $urandom_range(4, 1);
        for (int ln = 0; ln < nlines; ln++) begin
            nparts = $urandom_range(12);
            for (int k = 0; k < nparts; k++) begin
                r = $urandom_range(99);
                if (noise || r >= 75) begin
                    b = 8'($urandom_range(255));
                    send_word(b, 1'b0);
                end else if (r < 35) begin
                    for (int i = 0; i < active_len(); i++) send_word(pat_byte(i), 1'b0);
                end else begin
                    send_word(alpha[$urandom_range(2)], 1'b0);
                end
                // now and then retune the pattern with the line still open
                if ($urandom_range(99) == 0) begin
                    wait_quiet();
                    pick_pattern();
                end
            end
            if (ln < nlines - 1 || $urandom_range(1) == 0) send_word(NEWLINE, 1'b0);
        end
        b = 8'($urandom_range(255));
        send_word(b, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty pattern straight out of reset: every line reports a zero count,
    // including an empty final line closed by the end marker.
    task automatic test_empty_pattern();
        send_word(NEWLINE, 1'b0);
        send_word(8'hFF, 1'b1);
        wait_quiet();
    endtask

    // Non-overlapping count: "aaa" holds one "aa", a second line's "aa" one.
    task automatic test_non_overlap();
        set_pattern(5'd2, 64'h6161, 64'h0);
        repeat (3) send_word(8'h61, 1'b0);
        send_word(NEWLINE, 1'b0);
        repeat (2) send_word(8'h61, 1'b0);
        send_word(8'h00, 1'b1);
        wait_quiet();
    endtask

    // Oversized length clips to 16; the full pattern uses the byte extremes.
    task automatic test_full_window();
        set_pattern(5'd31, 64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00);
        for (int i = 0; i < PATTERN_BYTES; i++) send_word(pat_byte(i), 1'b0);
        send_word(NEWLINE, 1'b0);
        send_word(8'h0A, 1'b1);
        wait_quiet();
    endtask

    // Change the pattern mid-line: the window and the run carry over.
    task automatic test_midline_config();
        set_pattern(5'd1, 64'h71, 64'h0);
        send_word(8'h78, 1'b0);
        wait_quiet();
        set_pattern(5'd2, 64'h7978, 64'h0);
        send_word(8'h79, 1'b0);
        send_word(NEWLINE, 1'b0);
        send_word(8'h00, 1'b1);
        wait_quiet();
    endtask

    // Hold the receiver off while lines keep coming: fill the result queue
    // and stall the input, then release.
    task automatic test_backpressure();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        set_pattern('0, {$urandom, $urandom}, {$urandom, $urandom});
        rx_hold_req++;
        for (int i = 0; i < 40; i++) begin
            if ($urandom_range(3) == 0) send_word(alpha[$urandom_range(2)], 1'b0);
            else send_word(NEWLINE, 1'b0);
        end
        send_word(8'h55, 1'b1);
        wait_quiet();
    endtask

    // Random texts under one idle/stall mix.
    task automatic test_random_texts(input int send_pct, input int stall_pct,
                                     input int budget);
        int start;
        send_idle_pct = send_pct;
        rx_stall_pct  = stall_pct;
        start = words_sent;
        while (words_sent - start < budget) begin
            wait_quiet();
            pick_pattern();
            repeat ($urandom_range(3, 1)) send_random_text();
        end
        wait_quiet();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        cfg_len = '0;
        cfg_lo  = '0;
        cfg_hi  = '0;
        clear_text();
        for (int i = 0; i < 3; i++) alpha[i] = 8'(8'h61 + i);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pattern();
        test_non_overlap();
        test_full_window();
        test_midline_config();
        test_random_texts(0, 0, 110);
        test_backpressure();
        test_random_texts(77, 0, 110);
        test_random_texts(0, 77, 110);
        test_random_texts(26, 26, 110);

        // trailing margin for anything stray
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d text words under %0d pattern settings; %0d reports checked.",
                 words_sent, settings_used, reports_seen);
        $display("Mixes: free flow, sender gaps, receiver stalls, both, one long hold-off.");
        if (err_count == 0 && pending_reports.size() == 0) begin
            $display("tb_line_substring_counter OK");
        end else begin
            $display("%0d mismatches, %0d reports missing", err_count,
                     pending_reports.size());
            $display("tb_line_substring_counter NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/lsc_pkg.sv
src/lsc_match.sv
src/lsc_outq.sv
src/line_substring_counter.sv
dv/tb_line_substring_counter.sv
